>>> rtl/core/e2tm_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle to transform core.
package e2tm_pkg;

  localparam int AngleBitsDef   = 16;
  localparam int OutFracBitsDef = 16;
  localparam int CordicSteps    = 30;

  // Q30 working values with headroom for doubling
  typedef logic signed [35:0] q_t;
  typedef logic signed [33:0] ang_t;
  typedef logic signed [55:0] sp_t;

  localparam q_t CordicGain = 36'sd652032874;
  localparam q_t Q30One     = 36'sd1073741824;

  typedef struct packed {
    logic [2:0]               flip;
    logic signed [2:0][23:0]  sc;
    logic signed [2:0][55:0]  sp;
  } side_t;

  function automatic ang_t atan_turns(input logic [4:0] idx);
    ang_t r;
    unique case (idx)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051D;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2E;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2F9;
      5'd15: r = 34'sh00000517C;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A2F;
      5'd19: r = 34'sh000000517;
      5'd20: r = 34'sh00000028B;
      5'd21: r = 34'sh000000145;
      5'd22: r = 34'sh0000000A2;
      5'd23: r = 34'sh000000051;
      5'd24: r = 34'sh000000028;
      5'd25: r = 34'sh000000014;
      5'd26: r = 34'sh00000000A;
      5'd27: r = 34'sh000000005;
      5'd28: r = 34'sh000000002;
      5'd29: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 product rounded half up
  function automatic q_t mul_q30(input q_t a, input q_t b);
    logic signed [71:0] p;
    p = 72'(a) * 72'(b) + (72'sd1 <<< 29);
    return p[65:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/euler_to_transform_matrix_core.sv
// Euler angles, scale and position to three rows of an affine transform.
// Row 0 passes the CORDIC, product, row buffer and row sum registers; rows 1 and 2 follow.
// New items wait while busy_o is high, since the three output rows share one row datapath.
// The 30 CORDIC steps and the quaternion products are fully pipelined.
// Reset clears valid bits, row buffer state and issue counter only; the receiver cannot stall.
module euler_to_transform_matrix_core #(
  parameter int ANGLE_BITS    = e2tm_pkg::AngleBitsDef,
  parameter int OUT_FRAC_BITS = e2tm_pkg::OutFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        angle_x_i,
  input  logic [15:0]        angle_y_i,
  input  logic [15:0]        angle_z_i,
  input  logic signed [23:0] scale_x_i,
  input  logic signed [23:0] scale_y_i,
  input  logic signed [23:0] scale_z_i,
  input  logic signed [31:0] position_x_i,
  input  logic signed [31:0] position_y_i,
  input  logic signed [31:0] position_z_i,
  output logic               valid_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] entry_col0_o,
  output logic signed [31:0] entry_col1_o,
  output logic signed [31:0] entry_col2_o,
  output logic signed [31:0] entry_col3_o,
  output logic               last_row_o
);
  import e2tm_pkg::*;

  localparam logic [31:0] AngMask = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int          PhShift = 31 - ANGLE_BITS;
  localparam int          ShLin   = 46 - OUT_FRAC_BITS;
  localparam int          ShTr    = 38 - OUT_FRAC_BITS;

  // issue spacing: busy_o holds off new words while the gap counter runs down
  logic [1:0] gap_q, gap_d;
  logic       accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (gap_q != 2'd0);
  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = 2'd2;
    end else if (gap_q != 2'd0) begin
      gap_d = gap_q - 2'd1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else begin
      gap_q <= gap_d;
    end
  end

  // stage 0: phases, quadrant fold, scale times position
  logic [2:0][31:0] ph;
  logic [2:0]       flp;
  logic [2:0][31:0] phf;
  always_comb begin
    ph[0] = ({16'd0, angle_y_i} & AngMask) << PhShift;
    ph[1] = 32'd0 - (({16'd0, angle_z_i} & AngMask) << PhShift);
    ph[2] = ({16'd0, angle_x_i} & AngMask) << PhShift;
    for (int k = 0; k < 3; k++) begin
      flp[k] = ph[k][31] ^ ph[k][30];
      phf[k] = flp[k] ? (ph[k] + 32'h80000000) : ph[k];
    end
  end

  logic                 vld_q [CordicSteps+1];
  q_t   [2:0]           cx_q  [CordicSteps+1];
  q_t   [2:0]           cy_q  [CordicSteps+1];
  ang_t [2:0]           cz_q  [CordicSteps+1];
  side_t                sd_q  [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      cx_q[0][k]    <= CordicGain;
      cy_q[0][k]    <= '0;
      cz_q[0][k]    <= 34'(signed'(phf[k]));
    end
    sd_q[0].flip  <= flp;
    sd_q[0].sc[0] <= scale_x_i;
    sd_q[0].sc[1] <= scale_y_i;
    sd_q[0].sc[2] <= scale_z_i;
    sd_q[0].sp[0] <= 56'(scale_x_i) * 56'(position_x_i);
    sd_q[0].sp[1] <= 56'(scale_y_i) * 56'(position_y_i);
    sd_q[0].sp[2] <= 56'(scale_z_i) * 56'(position_z_i);
  end

  // one CORDIC rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        if (!cz_q[i][k][33]) begin
          cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] - atan_turns(5'(i));
        end else begin
          cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] + atan_turns(5'(i));
        end
      end
      sd_q[i+1] <= sd_q[i];
    end
  end

  // unfold quadrant
  logic       fl_vld_q;
  q_t [2:0]   c_q, s_q;
  side_t      fl_sd_q;
  // quaternion products
  logic       m1_vld_q;
  q_t         c1c2_q, s1s2_q, s1c2_q, c1s2_q, c3_q, s3_q;
  side_t      m1_sd_q;
  logic       m2_vld_q;
  q_t [7:0]   pp_q;
  side_t      m2_sd_q;
  logic       m3_vld_q;
  q_t         qw_q, qx_q, qy_q, qz_q;
  side_t      m3_sd_q;
  logic       m4_vld_q;
  q_t         xx_q, xy_q, xz_q, yy_q, yz_q, zz_q, wx_q, wy_q, wz_q;
  side_t      m4_sd_q;
  logic       m5_vld_q;
  q_t [2:0][2:0] r_q;
  side_t      m5_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_vld_q <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
      m5_vld_q <= 1'b0;
    end else begin
      fl_vld_q <= vld_q[CordicSteps];
      m1_vld_q <= fl_vld_q;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      m4_vld_q <= m3_vld_q;
      m5_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      c_q[k] <= sd_q[CordicSteps].flip[k] ? -cx_q[CordicSteps][k] : cx_q[CordicSteps][k];
      s_q[k] <= sd_q[CordicSteps].flip[k] ? -cy_q[CordicSteps][k] : cy_q[CordicSteps][k];
    end
    fl_sd_q <= sd_q[CordicSteps];

    c1c2_q  <= mul_q30(c_q[0], c_q[1]);
    s1s2_q  <= mul_q30(s_q[0], s_q[1]);
    s1c2_q  <= mul_q30(s_q[0], c_q[1]);
    c1s2_q  <= mul_q30(c_q[0], s_q[1]);
    c3_q    <= c_q[2];
    s3_q    <= s_q[2];
    m1_sd_q <= fl_sd_q;

    pp_q[0] <= mul_q30(c1c2_q, c3_q);
    pp_q[1] <= mul_q30(s1s2_q, s3_q);
    pp_q[2] <= mul_q30(c1c2_q, s3_q);
    pp_q[3] <= mul_q30(s1s2_q, c3_q);
    pp_q[4] <= mul_q30(s1c2_q, c3_q);
    pp_q[5] <= mul_q30(c1s2_q, s3_q);
    pp_q[6] <= mul_q30(c1s2_q, c3_q);
    pp_q[7] <= mul_q30(s1c2_q, s3_q);
    m2_sd_q <= m1_sd_q;

    qw_q    <= pp_q[0] - pp_q[1];
    qx_q    <= pp_q[2] + pp_q[3];
    qy_q    <= pp_q[4] + pp_q[5];
    qz_q    <= pp_q[6] - pp_q[7];
    m3_sd_q <= m2_sd_q;

    xx_q    <= mul_q30(qx_q, qx_q <<< 1);
    xy_q    <= mul_q30(qx_q, qy_q <<< 1);
    xz_q    <= mul_q30(qx_q, qz_q <<< 1);
    yy_q    <= mul_q30(qy_q, qy_q <<< 1);
    yz_q    <= mul_q30(qy_q, qz_q <<< 1);
    zz_q    <= mul_q30(qz_q, qz_q <<< 1);
    wx_q    <= mul_q30(qw_q, qx_q <<< 1);
    wy_q    <= mul_q30(qw_q, qy_q <<< 1);
    wz_q    <= mul_q30(qw_q, qz_q <<< 1);
    m4_sd_q <= m3_sd_q;

    r_q[0][0] <= Q30One - (yy_q + zz_q);
    r_q[0][1] <= xy_q - wz_q;
    r_q[0][2] <= xz_q + wy_q;
    r_q[1][0] <= xy_q + wz_q;
    r_q[1][1] <= Q30One - (xx_q + zz_q);
    r_q[1][2] <= yz_q - wx_q;
    r_q[2][0] <= xz_q - wy_q;
    r_q[2][1] <= yz_q + wx_q;
    r_q[2][2] <= Q30One - (xx_q + yy_q);
    m5_sd_q   <= m4_sd_q;
  end

  // row buffer: hold one matrix, advance one row per cycle
  logic                     rb_act_q;
  logic [1:0]               rb_row_q;
  q_t [2:0][2:0]            rb_r_q;
  logic signed [2:0][23:0]  rb_sc_q;
  logic signed [2:0][31:0]  rb_hi_q;
  logic [2:0][23:0]         rb_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_act_q <= 1'b0;
      rb_row_q <= '0;
    end else if (m5_vld_q) begin
      rb_act_q <= 1'b1;
      rb_row_q <= '0;
    end else if (rb_act_q) begin
      rb_row_q <= rb_row_q + 2'd1;
      rb_act_q <= (rb_row_q != 2'd2);
    end
  end
  always_ff @(posedge clk_i) begin
    if (m5_vld_q) begin
      rb_r_q  <= r_q;
      rb_sc_q <= m5_sd_q.sc;
      for (int j = 0; j < 3; j++) begin
        rb_hi_q[j] <= m5_sd_q.sp[j][55:24];
        rb_lo_q[j] <= m5_sd_q.sp[j][23:0];
      end
    end
  end

  // row products
  q_t [2:0] rsel;
  always_comb begin
    rsel = rb_r_q[0];
    unique case (rb_row_q)
      2'd0:    rsel = rb_r_q[0];
      2'd1:    rsel = rb_r_q[1];
      default: rsel = rb_r_q[2];
    endcase
  end

  logic                    p1_vld_q;
  logic [1:0]              p1_row_q;
  logic signed [2:0][59:0] lin_q;
  logic signed [2:0][67:0] th_q;
  logic signed [2:0][60:0] tl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= rb_act_q;
    end
  end
  always_ff @(posedge clk_i) begin
    p1_row_q <= rb_row_q;
    for (int j = 0; j < 3; j++) begin
      lin_q[j] <= 60'(rsel[j]) * 60'($signed(rb_sc_q[j]));
      th_q[j]  <= 68'(rsel[j]) * 68'($signed(rb_hi_q[j]));
      tl_q[j]  <= 61'(rsel[j]) * 61'(signed'({1'b0, rb_lo_q[j]}));
    end
  end

  // rounding and row sums
  logic                    p2_vld_q;
  logic [1:0]              p2_row_q;
  logic signed [2:0][71:0] e_q;
  logic signed [71:0]      hs_q, ls_q;
  logic signed [71:0]      lsum;
  always_comb begin
    lsum = 72'($signed(tl_q[0])) + 72'($signed(tl_q[1])) + 72'($signed(tl_q[2])) +
           (72'sd1 <<< (ShTr + 23));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    p2_row_q <= p1_row_q;
    for (int j = 0; j < 3; j++) begin
      e_q[j] <= (72'($signed(lin_q[j])) + (72'sd1 <<< (ShLin - 1))) >>> ShLin;
    end
    hs_q <= 72'($signed(th_q[0])) + 72'($signed(th_q[1])) + 72'($signed(th_q[2]));
    ls_q <= lsum >>> 24;
  end

  // saturate and drive the result word
  logic               out_vld_q;
  logic [1:0]         out_row_q;
  logic signed [31:0] o0_q, o1_q, o2_q, o3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    out_row_q <= p2_row_q;
    o0_q      <= sat32(e_q[0]);
    o1_q      <= sat32(e_q[1]);
    o2_q      <= sat32(e_q[2]);
    o3_q      <= sat32((hs_q + ls_q) >>> ShTr);
  end

  assign valid_o      = out_vld_q;
  assign row_index_o  = out_row_q;
  assign entry_col0_o = o0_q;
  assign entry_col1_o = o1_q;
  assign entry_col2_o = o2_q;
  assign entry_col3_o = o3_q;
  assign last_row_o   = (out_row_q == 2'd2);

`ifndef SYNTH
  a_row0_then_row1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && row_index_o == 2'd0 |=> valid_o && row_index_o == 2'd1)
    else $error("row 1 did not follow row 0");
  a_row1_then_row2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && row_index_o == 2'd1 |=> valid_o && last_row_o)
    else $error("final row did not follow row 1");
  a_issue_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o ##1 busy_o)
    else $error("issue spacing broken");
  a_rb_idle_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m5_vld_q |-> !rb_act_q || rb_row_q == 2'd2)
    else $error("row buffer overwritten mid matrix");
`endif

endmodule

>>> test/tb_euler_to_transform_matrix_core.sv
// Self-checking testbench for the Euler angle to affine transform core.
`timescale 1ns / 1ps

module tb_euler_to_transform_matrix_core;
  import e2tm_pkg::*;

  localparam int NumRandom    = 150;
  localparam int CalmTail     = 30;
  localparam int WatchdogMax  = 4000;
  localparam int DrainCycles  = 60;
  localparam longint OneQ30   = 64'sd1073741824;
  localparam longint GainQ30  = 64'sd652032874;
  localparam logic signed [23:0] ScaleOne = 24'sd65536;

  typedef struct {
    logic [15:0]        ax, ay, az;
    logic signed [23:0] sx, sy, sz;
    logic signed [31:0] px, py, pz;
    bit                 zero_row;  // all entries read zero: all three scales are zero
  } pose_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0, c1, c2, c3;
    logic               last;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [15:0]        angle_x_i, angle_y_i, angle_z_i;
  logic signed [23:0] scale_x_i, scale_y_i, scale_z_i;
  logic signed [31:0] position_x_i, position_y_i, position_z_i;
  logic               valid_o;
  logic [1:0]         row_index_o;
  logic signed [31:0] entry_col0_o, entry_col1_o, entry_col2_o, entry_col3_o;
  logic               last_row_o;

  row_t   pending_rows[$];
  pose_t  poses[$];
  int     errors;
  int     idle_cnt;

  euler_to_transform_matrix_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .angle_x_i   (angle_x_i),
    .angle_y_i   (angle_y_i),
    .angle_z_i   (angle_z_i),
    .scale_x_i   (scale_x_i),
    .scale_y_i   (scale_y_i),
    .scale_z_i   (scale_z_i),
    .position_x_i(position_x_i),
    .position_y_i(position_y_i),
    .position_z_i(position_z_i),
    .valid_o     (valid_o),
    .row_index_o (row_index_o),
    .entry_col0_o(entry_col0_o),
    .entry_col1_o(entry_col1_o),
    .entry_col2_o(entry_col2_o),
    .entry_col3_o(entry_col3_o),
    .last_row_o  (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint round_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // CORDIC on a 32 bit phase, full turn 2^32; results in Q30
  task automatic cordic_sin_cos(input logic [31:0] ph, output longint c, output longint s);
    longint atan_tab [30] = '{
      'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
      'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
      'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
      'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
    logic [31:0] t;
    bit          flip;
    longint      x, y, z, dx, dy;
    t = ph + 32'h4000_0000;
    flip = t[31];
    if (flip) ph = ph + 32'h8000_0000;
    z = longint'($signed(ph));
    x = GainQ30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  // Build the three rows of the 3x4 transform for one pose
  task automatic predict_transform(input pose_t p);
    longint c1, s1, c2, s2, c3, s3, c1c2, s1s2, s1c2, c1s2;
    longint qw, qx, qy, qz, xx, xy, xz, yy, yz, zz, wx, wy, wz;
    longint sc[3], sp[3], r[3][3];
    longint hi, lo, hi_sum, lo_sum;
    row_t   rw;
    sc[0] = p.sx; sc[1] = p.sy; sc[2] = p.sz;
    sp[0] = sc[0] * longint'(p.px);
    sp[1] = sc[1] * longint'(p.py);
    sp[2] = sc[2] * longint'(p.pz);
    cordic_sin_cos({1'b0, p.ay, 15'b0}, c1, s1);
    cordic_sin_cos(32'h0 - {1'b0, p.az, 15'b0}, c2, s2);
    cordic_sin_cos({1'b0, p.ax, 15'b0}, c3, s3);
    c1c2 = round_q30(c1, c2);
    s1s2 = round_q30(s1, s2);
    s1c2 = round_q30(s1, c2);
    c1s2 = round_q30(c1, s2);
    qw = round_q30(c1c2, c3) - round_q30(s1s2, s3);
    qx = round_q30(c1c2, s3) + round_q30(s1s2, c3);
    qy = round_q30(s1c2, c3) + round_q30(c1s2, s3);
    qz = round_q30(c1s2, c3) - round_q30(s1c2, s3);
    xx = round_q30(qx, 2 * qx); xy = round_q30(qx, 2 * qy); xz = round_q30(qx, 2 * qz);
    yy = round_q30(qy, 2 * qy); yz = round_q30(qy, 2 * qz); zz = round_q30(qz, 2 * qz);
    wx = round_q30(qw, 2 * qx); wy = round_q30(qw, 2 * qy); wz = round_q30(qw, 2 * qz);
    r[0][0] = OneQ30 - (yy + zz); r[0][1] = xy - wz; r[0][2] = xz + wy;
    r[1][0] = xy + wz; r[1][1] = OneQ30 - (xx + zz); r[1][2] = yz - wx;
    r[2][0] = xz - wy; r[2][1] = yz + wx; r[2][2] = OneQ30 - (xx + yy);
    for (int i = 0; i < 3; i++) begin
      hi_sum = 0;
      lo_sum = 0;
      for (int j = 0; j < 3; j++) begin
        hi = sp[j] >>> 24;
        lo = sp[j] - hi * 64'sd16777216;
        hi_sum += r[i][j] * hi;
        lo_sum += r[i][j] * lo;
      end
      lo_sum += 64'sd1 <<< 45;
      rw.row  = i[1:0];
      rw.c0   = clip32((r[i][0] * sc[0] + (64'sd1 <<< 29)) >>> 30);
      rw.c1   = clip32((r[i][1] * sc[1] + (64'sd1 <<< 29)) >>> 30);
      rw.c2   = clip32((r[i][2] * sc[2] + (64'sd1 <<< 29)) >>> 30);
      rw.c3   = clip32((hi_sum + (lo_sum >>> 24)) >>> 22);
      rw.last = (i == 2);
      pending_rows.push_back(rw);
    end
  endtask

  function automatic pose_t mk(input logic [15:0] ax, ay, az,
                               input logic signed [23:0] sx, sy, sz,
                               input logic signed [31:0] px, py, pz);
    pose_t p;
    p = '{ax, ay, az, sx, sy, sz, px, py, pz, 1'b0};
    p.zero_row = (sx == 0 && sy == 0 && sz == 0) || (px == 0 && py == 0 && pz == 0 &&
                 sx == 0 && sy == 0 && sz == 0);
    return p;
  endfunction

  function automatic logic signed [23:0] rnd_scale();
    case ($urandom_range(0, 3))
      0: return 24'($signed($urandom));
      1: return 24'sd65536 + $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      2: return -24'sd65536;
      default: return $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_pos();
    if ($urandom_range(0, 2) == 0) return $signed($urandom);
    return $signed(32'($urandom_range(0, 33554431))) - 32'sd16777216;
  endfunction

  // Hold start until the core takes the word, then queue its rows
  task automatic send_pose(input pose_t p);
    row_t z;
    start_i      <= 1'b1;
    angle_x_i    <= p.ax;
    angle_y_i    <= p.ay;
    angle_z_i    <= p.az;
    scale_x_i    <= p.sx;
    scale_y_i    <= p.sy;
    scale_z_i    <= p.sz;
    position_x_i <= p.px;
    position_y_i <= p.py;
    position_z_i <= p.pz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (p.zero_row) begin
      for (int i = 0; i < 3; i++) begin
        z = '{i[1:0], 32'sd0, 32'sd0, 32'sd0, 32'sd0, i == 2};
        pending_rows.push_back(z);
      end
    end else begin
      predict_transform(p);
    end
  endtask

  task automatic drain_rows();
    start_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // Compare each row word against the oldest expectation
  always @(posedge clk_i) begin
    row_t e;
    if (rst_ni && valid_o) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row: got row %0d %h %h %h %h last %b", $time,
                 row_index_o, entry_col0_o, entry_col1_o, entry_col2_o, entry_col3_o,
                 last_row_o);
        errors++;
      end else begin
        e = pending_rows.pop_front();
        if (row_index_o !== e.row || entry_col0_o !== e.c0 || entry_col1_o !== e.c1 ||
            entry_col2_o !== e.c2 || entry_col3_o !== e.c3 || last_row_o !== e.last) begin
          $display("%0t: row mismatch: expected row %0d %h %h %h %h last %b", $time,
                   e.row, e.c0, e.c1, e.c2, e.c3, e.last);
          $display("%0t:               actual   row %0d %h %h %h %h last %b", $time,
                   row_index_o, entry_col0_o, entry_col1_o, entry_col2_o, entry_col3_o,
                   last_row_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogMax) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pose_t p;
    errors       = 0;
    idle_cnt     = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    angle_x_i    = '0; angle_y_i = '0; angle_z_i = '0;
    scale_x_i    = '0; scale_y_i = '0; scale_z_i = '0;
    position_x_i = '0; position_y_i = '0; position_z_i = '0;

    // directed poses: zero pose, angle extremes, scale and position extremes
    poses.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    poses.push_back(mk(16'hFFFF, 16'h1234, 16'h8000, 0, 0, 0,
                       32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678));
    poses.push_back(mk(0, 0, 0, ScaleOne, ScaleOne, ScaleOne, 0, 0, 0));
    poses.push_back(mk(16'h4000, 0, 0, ScaleOne, ScaleOne, ScaleOne, 32'sh10000, 0, 0));
    poses.push_back(mk(0, 16'h4000, 0, ScaleOne, ScaleOne, ScaleOne, 0, 32'sh10000, 0));
    poses.push_back(mk(0, 0, 16'h4000, ScaleOne, ScaleOne, ScaleOne, 0, 0, 32'sh10000));
    poses.push_back(mk(16'h8000, 16'h8000, 16'h8000, ScaleOne, ScaleOne, ScaleOne,
                       32'sh10000, 32'sh20000, 32'sh30000));
    poses.push_back(mk(16'hC000, 16'hC000, 16'hC000, ScaleOne, ScaleOne, ScaleOne,
                       -32'sh10000, 32'sh10000, -32'sh10000));
    poses.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, ScaleOne, ScaleOne, ScaleOne,
                       32'sh1, 32'sh1, 32'sh1));
    poses.push_back(mk(16'h0001, 16'h0001, 16'h0001, ScaleOne, ScaleOne, ScaleOne, 0, 0, 0));
    poses.push_back(mk(16'h2000, 16'h6000, 16'hA000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                       32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    poses.push_back(mk(16'h2000, 16'h6000, 16'hA000, 24'sh800000, 24'sh800000, 24'sh800000,
                       32'sh80000000, 32'sh80000000, 32'sh80000000));
    poses.push_back(mk(0, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                       32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
    poses.push_back(mk(16'h1555, 16'h2AAA, 16'hE000, -24'sd65536, ScaleOne, -24'sd65536,
                       32'sh00050000, -32'sh00030000, 32'sh00001000));
    poses.push_back(mk(16'h3FFF, 16'h4001, 16'hBFFF, 24'sd1, -24'sd1, 24'sd0,
                       32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    poses.push_back(mk(16'h7FFF, 16'h8001, 16'h5555, 24'sd32768, 24'sd131072, 24'sd196608,
                       32'sh00640000, 32'sh00C80000, -32'sh012C0000));
    poses.push_back(mk(16'hAAAA, 16'h5555, 16'h0F0F, 0, ScaleOne, 0,
                       32'sh7FFF0000, 32'sh7FFF0000, 32'sh7FFF0000));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (poses[k]) send_pose(poses[k]);
    drain_rows();

    for (int n = 0; n < NumRandom; n++) begin
      if (n < NumRandom - CalmTail && $urandom_range(0, 3) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      if (n == NumRandom / 2) drain_rows();
      p = mk(16'($urandom), 16'($urandom), 16'($urandom), rnd_scale(), rnd_scale(),
             rnd_scale(), rnd_pos(), rnd_pos(), rnd_pos());
      send_pose(p);
    end
    drain_rows();
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/e2tm_pkg.sv
rtl/core/euler_to_transform_matrix_core.sv
test/tb_euler_to_transform_matrix_core.sv
